FILE: rtl/core/sliding_window_median_top_assert.svh
// assertion macros for the sliding window median block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SWM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SWM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/swm_pkg.sv
// shared constants, codes and types of the sliding window median block
// no dependencies
`timescale 1ns / 1ps

package swm_pkg;

  // number of stored samples
  localparam int DEPTH    = 16;
  localparam int SAMPLE_W = 16;
  localparam int FUNC_W   = 2;
  localparam int WIN_W    = 5;
  // index of a cell, and a count that can hold DEPTH itself
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  // width for window length, rank and count comparisons
  localparam int CMP_W    = (CNT_W > WIN_W) ? CNT_W : WIN_W;

  // operation codes of an input word
  typedef enum logic [FUNC_W-1:0] {
    FUNC_FILL    = 2'd0,
    FUNC_PUSH    = 2'd1,
    FUNC_REPLACE = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_e;

  // what a cell does with its sample register this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     tag_set;
    logic     tag_val;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/swm_in_if.sv
// input channel of the sliding window median block
// depends on swm_pkg
`timescale 1ns / 1ps

interface swm_in_if import swm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [SAMPLE_W-1:0] sample;
  logic [WIN_W-1:0]           window_len;

  modport source (output valid, output func, output sample, output window_len, input ready);
  modport sink (input valid, input func, input sample, input window_len, output ready);
endinterface

FILE: rtl/core/swm_out_if.sv
// output channel of the sliding window median block
// depends on swm_pkg
`timescale 1ns / 1ps

interface swm_out_if import swm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

FILE: rtl/core/sliding_window_median_top.sv
// Sliding window lower-median filter. The last DEPTH samples sit in a chain of
// cells, oldest first. A word applies fill, push, replace or query, then the
// chain rotates once around, one cell per cycle; each cycle the sample leaving
// the newest cell is the candidate, every cell compares against it, and the
// candidate whose rank brackets floor((n+1)/2) is kept. A word is applied on
// acceptance, then the chain rotates, then the result is handed over once the
// output register is free; no new word is accepted until then. A finished
// result waits in an output register while the next word is processed.
// depends on swm_pkg, swm_in_if, swm_out_if, swm_cell and the assertion header
`timescale 1ns / 1ps

`include "sliding_window_median_top_assert.svh"

module sliding_window_median_top import swm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  swm_in_if.sink     in_i,
  swm_out_if.source  out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                     state_q;
  logic [IDX_W-1:0]           cnt_q;
  logic [CMP_W-1:0]           k_q;
  logic signed [SAMPLE_W-1:0] found_q;
  logic signed [SAMPLE_W-1:0] med_q;
  logic                       out_valid_q;

  logic                       in_fire;
  logic                       out_free;
  logic [CMP_W-1:0]           win_ext;
  logic [CMP_W-1:0]           n_eff;
  logic [CMP_W:0]             n_plus;
  logic [CMP_W-1:0]           k_new;

  cell_ctrl_t                 ctrl [DEPTH];
  logic signed [SAMPLE_W-1:0] value [DEPTH];
  logic                       tag [DEPTH];
  logic                       lt [DEPTH];
  logic                       le [DEPTH];
  logic                       tag_init [DEPTH];

  logic signed [SAMPLE_W-1:0] cand;
  logic                       cand_tag;
  logic [CMP_W-1:0]           lt_cnt;
  logic [CMP_W-1:0]           le_cnt;
  logic                       hit;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // effective window length and rank of the lower median
  assign win_ext = CMP_W'(in_i.window_len);
  assign n_eff   = ((win_ext == '0) || (win_ext > CMP_W'(DEPTH))) ? CMP_W'(DEPTH) : win_ext;
  assign n_plus  = {1'b0, n_eff} + (CMP_W+1)'(1);
  assign k_new   = n_plus[CMP_W:1];

  // cell chain, each cell takes its upper neighbor, the oldest wraps to the newest
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign tag_init[i] = ((CMP_W+1)'(i) + {1'b0, n_eff}) >= (CMP_W+1)'(DEPTH);

    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[i]),
      .sample_i    (in_i.sample),
      .nbr_value_i (value[(i + 1) % DEPTH]),
      .nbr_tag_i   (tag[(i + 1) % DEPTH]),
      .cand_i      (cand),
      .value_o     (value[i]),
      .tag_o       (tag[i]),
      .lt_o        (lt[i]),
      .le_o        (le[i])
    );
  end

  // per-cell control: apply the operation on accept, rotate during the pass
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i] = '{op: CELL_HOLD, tag_set: 1'b0, tag_val: 1'b0};
      if (in_fire) begin
        ctrl[i].tag_set = 1'b1;
        ctrl[i].tag_val = tag_init[i];
        unique case (func_e'(in_i.func))
          FUNC_FILL:    ctrl[i].op = CELL_LOAD;
          FUNC_PUSH:    ctrl[i].op = (i == DEPTH - 1) ? CELL_LOAD : CELL_SHIFT;
          FUNC_REPLACE: ctrl[i].op = (i == DEPTH - 1) ? CELL_LOAD : CELL_HOLD;
          default:      ctrl[i].op = CELL_HOLD;
        endcase
      end else if (state_q == ST_RUN) begin
        ctrl[i].op = CELL_SHIFT;
      end
    end
  end

  // candidate is the newest cell; count window entries below and up to it
  assign cand     = value[DEPTH-1];
  assign cand_tag = tag[DEPTH-1];

  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lt_cnt = lt_cnt + CMP_W'(lt[i]);
      le_cnt = le_cnt + CMP_W'(le[i]);
    end
  end

  assign hit = cand_tag && (lt_cnt < k_q) && (k_q <= le_cnt);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      found_q     <= '0;
      med_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result valid: set when a finished pass hands over, cleared when taken
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            k_q     <= k_new;
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (hit) begin
            found_q <= cand;
          end
          cnt_q <= cnt_q + IDX_W'(1);
          if (cnt_q == IDX_W'(DEPTH - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            med_q   <= found_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.median = med_q;

  // a full rotation brings the newest sample, always in the window, back in place
  `SWM_ASSERT_IMP(a_rotation_restored, state_q == ST_DONE, tag[DEPTH-1], "chain not rotated back")
  // an accepted word starts a rank pass
  `SWM_ASSERT_NXT(a_accept_starts_pass, in_fire, state_q == ST_RUN, "accept did not start pass")
  // a finished pass with room downstream presents the selected sample
  `SWM_ASSERT_NXT(a_done_presents, (state_q == ST_DONE) && out_free,
                  out_o.valid && (out_o.median == $past(found_q)), "result not presented")

endmodule

FILE: rtl/core/swm_cell.sv
// one cell of the sample chain: a stored sample, its window tag and a compare
// depends on swm_pkg
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [SAMPLE_W-1:0] nbr_value_i,
  input  logic                       nbr_tag_i,
  input  logic signed [SAMPLE_W-1:0] cand_i,
  output logic signed [SAMPLE_W-1:0] value_o,
  output logic                       tag_o,
  output logic                       lt_o,
  output logic                       le_o
);

  logic signed [SAMPLE_W-1:0] value_d, value_q;
  logic                       tag_d, tag_q;

  // next sample: keep, take the neighbor's, or load the new one
  always_comb begin
    unique case (ctrl_i.op)
      CELL_SHIFT: value_d = nbr_value_i;
      CELL_LOAD:  value_d = sample_i;
      default:    value_d = value_q;
    endcase
  end

  // window tag travels with the sample unless set directly
  always_comb begin
    priority if (ctrl_i.tag_set) begin
      tag_d = ctrl_i.tag_val;
    end else if (ctrl_i.op == CELL_SHIFT) begin
      tag_d = nbr_tag_i;
    end else begin
      tag_d = tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      tag_q   <= 1'b0;
    end else begin
      value_q <= value_d;
      tag_q   <= tag_d;
    end
  end

  // compare against the candidate, counted only inside the window
  assign lt_o    = tag_q && (value_q < cand_i);
  assign le_o    = tag_q && (value_q <= cand_i);
  assign value_o = value_q;
  assign tag_o   = tag_q;

endmodule

FILE: dv/swm_median_checker.sv
// checker for the sliding window median block: watches both channels, keeps a
// shadow copy of the sample window and compares every returned median
// depends on swm_pkg, swm_in_if and swm_out_if
`timescale 1ns / 1ps

module swm_median_checker import swm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  swm_in_if    in_mon,
  swm_out_if   out_mon,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o
);

  localparam int MAX_PRINTS = 20;

  // shadow window, slot 0 oldest, slot DEPTH-1 newest
  logic signed [SAMPLE_W-1:0] shadow_win [DEPTH];
  logic signed [SAMPLE_W-1:0] median_fifo [$];
  logic signed [SAMPLE_W-1:0] want_median;
  int err_cnt = 0;
  int chk_cnt = 0;
  int pend_cnt = 0;
  int win_len;

  assign errors_o  = err_cnt;
  assign pending_o = pend_cnt;
  assign checked_o = chk_cnt;

  task automatic report(string what, int want, int got);
    if (err_cnt < MAX_PRINTS) begin
      $display("%0t ns: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
    err_cnt++;
  endtask

  // k-th smallest of the newest n slots, k = (n+1)/2: a slot holds the answer
  // when fewer than k entries are below it and at least k are at or below it
  function automatic logic signed [SAMPLE_W-1:0] lower_median(int n);
    int k;
    int below;
    int at_or_below;
    logic signed [SAMPLE_W-1:0] found;
    k = (n + 1) / 2;
    found = shadow_win[DEPTH-1];
    for (int i = DEPTH - n; i < DEPTH; i++) begin
      below = 0;
      at_or_below = 0;
      for (int j = DEPTH - n; j < DEPTH; j++) begin
        if (shadow_win[j] < shadow_win[i]) below++;
        if (shadow_win[j] <= shadow_win[i]) at_or_below++;
      end
      if (below < k && at_or_below >= k) found = shadow_win[i];
    end
    return found;
  endfunction

  // compare returned words first, then predict for the accepted input word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) shadow_win[i] = '0;
      median_fifo.delete();
      pend_cnt = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (median_fifo.size() == 0) begin
          report("median word with nothing outstanding", 0, out_mon.median);
        end else begin
          want_median = median_fifo.pop_front();
          chk_cnt++;
          if (out_mon.median !== want_median) begin
            report("median", want_median, out_mon.median);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        win_len = int'(in_mon.window_len);
        if (win_len == 0 || win_len > DEPTH) win_len = DEPTH;
        case (func_e'(in_mon.func))
          FUNC_FILL: begin
            for (int i = 0; i < DEPTH; i++) shadow_win[i] = in_mon.sample;
          end
          FUNC_PUSH: begin
            for (int i = 0; i < DEPTH - 1; i++) shadow_win[i] = shadow_win[i+1];
            shadow_win[DEPTH-1] = in_mon.sample;
          end
          FUNC_REPLACE: begin
            shadow_win[DEPTH-1] = in_mon.sample;
          end
          default: ;
        endcase
        median_fifo.push_back(lower_median(win_len));
      end
      pend_cnt = median_fifo.size();
    end
  end

endmodule

FILE: dv/tb.sv
// top of the sliding window median testbench: clock, reset, stimulus,
// output back-pressure, watchdog and verdict
// depends on swm_pkg, swm_in_if, swm_out_if, sliding_window_median_top, swm_median_checker
`timescale 1ns / 1ps

module tb;
  import swm_pkg::*;

  localparam int N_RANDOM   = 700;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYC  = 2 * (DEPTH + 2) + 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   burst = 1'b0;
  int   errors;
  int   pending;
  int   checked;
  int   idle_cyc = 0;
  int   op_cnt [4] = '{0, 0, 0, 0};

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  sliding_window_median_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  swm_median_checker mon (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  always #2 clk = ~clk;

  // send one word; entered and left at a falling edge
  task automatic send(func_e f, logic signed [SAMPLE_W-1:0] s, logic [WIN_W-1:0] wl);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func       <= f;
    in_ch.sample     <= s;
    in_ch.window_len <= wl;
    in_ch.valid      <= 1'b1;
    op_cnt[int'(f)]++;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // mostly wide random values, some narrow ones for ties, some extremes
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SAMPLE_W'($urandom);
    if (r < 8) return SAMPLE_W'($urandom_range(0, 6) - 3);
    if (r < 9) return 16'sh8000;
    return 16'sh7fff;
  endfunction

  // window mostly in range, some zero and some oversized
  function automatic logic [WIN_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return WIN_W'($urandom_range(DEPTH + 1, 31));
    return WIN_W'($urandom_range(1, DEPTH));
  endfunction

  function automatic func_e pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return FUNC_FILL;
    if (r < 70) return FUNC_PUSH;
    if (r < 85) return FUNC_REPLACE;
    return FUNC_QUERY;
  endfunction

  // output back-pressure
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int stall;
      stall = burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_QUERY;
    in_ch.sample     = '0;
    in_ch.window_len = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes, every operation, window saturation, ties
    send(FUNC_QUERY,   16'sh1234, 5'd0);
    send(FUNC_FILL,    16'sh8000, 5'd0);
    send(FUNC_QUERY,   16'sh7fff, 5'd0);
    send(FUNC_PUSH,    16'sh7fff, 5'd1);
    send(FUNC_PUSH,    16'sh7fff, 5'd2);
    send(FUNC_QUERY,   16'sh0000, 5'd3);
    send(FUNC_REPLACE, -16'sd1,   5'd2);
    send(FUNC_QUERY,   16'sh0000, 5'd16);
    send(FUNC_QUERY,   16'sh0000, 5'd17);
    send(FUNC_QUERY,   16'shffff, 5'd31);
    send(FUNC_FILL,    16'sh0000, 5'd16);
    send(FUNC_PUSH,    16'sd5,    5'd4);
    send(FUNC_PUSH,    -16'sd7,   5'd5);
    send(FUNC_PUSH,    16'sd3,    5'd4);
    send(FUNC_PUSH,    16'sd3,    5'd3);
    send(FUNC_PUSH,    16'sd3,    5'd6);
    send(FUNC_REPLACE, 16'sh8000, 5'd1);
    send(FUNC_QUERY,   16'sh5555, 5'd7);
    send(FUNC_FILL,    16'sh7fff, 5'd8);
    send(FUNC_REPLACE, 16'sh8000, 5'd0);
    send(FUNC_QUERY,   16'shaaaa, 5'd2);

    // random words, with no-idle stretches
    for (int i = 0; i < N_RANDOM; i++) begin
      burst = (i % 100) < 25;
      send(pick_func(), pick_sample(), pick_window());
    end
    burst = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    $display("words sent: %0d fill, %0d push, %0d replace, %0d query",
             op_cnt[FUNC_FILL], op_cnt[FUNC_PUSH], op_cnt[FUNC_REPLACE], op_cnt[FUNC_QUERY]);
    $display("medians compared: %0d, mismatches: %0d", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
